// ===== rtl/core/pidb_pkg.sv =====
// ----------------------------------------------------------------------------
// pidb_pkg
// Shared types, codes and the microcode program for the PID controller with
// band indicator.
// ----------------------------------------------------------------------------
package pidb_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_GAIN_P = 3'd2;
  localparam logic [2:0] REG_GAIN_I = 3'd3;
  localparam logic [2:0] REG_GAIN_D = 3'd4;

  // Register reset values
  localparam logic [15:0] TARGET_RST = 16'd20;
  localparam logic [15:0] PERIOD_RST = 16'd100;
  localparam logic [15:0] GAIN_RST   = 16'd1;

  // Band codes
  localparam logic [1:0] BAND_ABOVE  = 2'd0;
  localparam logic [1:0] BAND_BELOW  = 2'd1;
  localparam logic [1:0] BAND_WITHIN = 2'd2;

  // Divider: 25-bit magnitude dividend, one quotient bit per step
  localparam int unsigned DIV_BITS = 25;
  localparam logic [4:0]  DIV_LAST = 5'(DIV_BITS - 1);

  // Multiplier operand select
  localparam logic [2:0] MUL_NONE    = 3'd0;
  localparam logic [2:0] MUL_ERR_PER = 3'd1;
  localparam logic [2:0] MUL_P       = 3'd2;
  localparam logic [2:0] MUL_I       = 3'd3;
  localparam logic [2:0] MUL_D       = 3'd4;

  // Accumulator operation
  localparam logic [1:0] ACC_NONE     = 2'd0;
  localparam logic [1:0] ACC_LOAD_SH8 = 2'd1;
  localparam logic [1:0] ACC_ADD_SH8  = 2'd2;
  localparam logic [1:0] ACC_ADD      = 2'd3;

  // Unit operation
  localparam logic [2:0] UOP_NONE     = 3'd0;
  localparam logic [2:0] UOP_ERR      = 3'd1;
  localparam logic [2:0] UOP_INTEG    = 3'd2;
  localparam logic [2:0] UOP_DIV_INIT = 3'd3;
  localparam logic [2:0] UOP_DIV_STEP = 3'd4;
  localparam logic [2:0] UOP_DIV_FIN  = 3'd5;
  localparam logic [2:0] UOP_DONE     = 3'd6;

  // Program addresses
  localparam logic [3:0] PC_ERR     = 4'd0;
  localparam logic [3:0] PC_MUL_EP  = 4'd1;
  localparam logic [3:0] PC_INTEG   = 4'd2;
  localparam logic [3:0] PC_MUL_P   = 4'd3;
  localparam logic [3:0] PC_MUL_I   = 4'd4;
  localparam logic [3:0] PC_ADD_I   = 4'd5;
  localparam logic [3:0] PC_DIV     = 4'd6;
  localparam logic [3:0] PC_DIV_FIN = 4'd7;
  localparam logic [3:0] PC_MUL_D   = 4'd8;
  localparam logic [3:0] PC_ADD_D   = 4'd9;
  localparam logic [3:0] PC_DONE    = 4'd10;

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] period;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } cfg_t;

  // One control word
  typedef struct packed {
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic [2:0] unit_op;
    logic       loop;     // repeat this step while the divider is busy
    logic       last;
  } ctrl_t;

  // Sequencer to datapath
  typedef struct packed {
    logic  load;          // input transfer: capture the sample
    logic  step;          // execute the control word this cycle
    ctrl_t cw;
  } dp_cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  // Microcode ROM
  function automatic ctrl_t pidb_rom(input logic [3:0] pc);
    ctrl_t cw;
    cw = '0;
    case (pc)
      PC_ERR:     cw.unit_op = UOP_ERR;
      PC_MUL_EP:  cw.mul_sel = MUL_ERR_PER;
      PC_INTEG:   cw.unit_op = UOP_INTEG;
      PC_MUL_P: begin
        cw.mul_sel = MUL_P;
        cw.unit_op = UOP_DIV_INIT;
      end
      PC_MUL_I: begin
        cw.mul_sel = MUL_I;
        cw.acc_op  = ACC_LOAD_SH8;
      end
      PC_ADD_I:   cw.acc_op = ACC_ADD_SH8;
      PC_DIV: begin
        cw.unit_op = UOP_DIV_STEP;
        cw.loop    = 1'b1;
      end
      PC_DIV_FIN: cw.unit_op = UOP_DIV_FIN;
      PC_MUL_D:   cw.mul_sel = MUL_D;
      PC_ADD_D:   cw.acc_op = ACC_ADD;
      PC_DONE: begin
        cw.unit_op = UOP_DONE;
        cw.last    = 1'b1;
      end
      default:    cw = '0;
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/pidb_seq.sv =====
// ----------------------------------------------------------------------------
// pidb_seq
// Step counter and handshake control: fetches one control word per cycle
// from the microcode ROM and holds the last step while the result waits.
// ----------------------------------------------------------------------------
module pidb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pidb_pkg::dp_stat_t stat,
  output pidb_pkg::dp_cmd_t  cmd
);
  import pidb_pkg::*;

  logic       busy;
  logic [3:0] pc;
  ctrl_t      cw;
  logic       stall;
  logic       step_en;
  logic       in_xfer;

  assign cw       = pidb_rom(pc);
  assign in_ready = !busy;
  assign in_xfer  = in_valid && !busy;
  // last step writes the output register; wait until it is free
  assign stall    = cw.last && out_valid && !out_ready;
  assign step_en  = busy && !stall;

  assign cmd.load = in_xfer;
  assign cmd.step = step_en;
  assign cmd.cw   = cw;

  // Step counter with self loop on the divider step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_ERR;
    end else if (in_xfer) begin
      busy <= 1'b1;
      pc   <= PC_ERR;
    end else if (step_en) begin
      if (cw.last) begin
        busy <= 1'b0;
        pc   <= PC_ERR;
      end else if (!(cw.loop && stat.div_busy)) begin
        pc <= pc + 4'd1;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && cw.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_idle_pc: assert property (@(posedge clk) disable iff (rst) !busy |-> pc == PC_ERR)
    else $error("step counter not at start while idle");
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    step_en && cw.last |=> out_valid && !busy)
    else $error("last step did not post a result");
  a_rose_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !busy && $past(busy))
    else $error("result posted outside the last step");

endmodule

// ===== rtl/core/pidb_dp.sv =====
// ----------------------------------------------------------------------------
// pidb_dp
// Datapath: error, shared multiplier, integral clamp, restoring divider,
// Q8 accumulator with drive saturation, controller state and result register.
// ----------------------------------------------------------------------------
module pidb_dp (
  input  logic               clk,
  input  logic               rst,
  input  pidb_pkg::cfg_t     cfg,
  input  pidb_pkg::dp_cmd_t  cmd,
  output pidb_pkg::dp_stat_t stat,
  input  logic signed [15:0] measured,
  output logic signed [16:0] err_now,
  output logic signed [31:0] integ_now,
  output logic signed [25:0] deriv_now,
  output logic signed [47:0] drive,
  output logic [1:0]         band
);
  import pidb_pkg::*;

  logic signed [15:0] meas_q;
  logic signed [16:0] err_q;
  logic signed [31:0] integ_q;
  logic signed [25:0] deriv_q;
  logic signed [50:0] prod_q;
  logic signed [57:0] acc_q;
  logic [15:0]        rem_q;
  logic [DIV_BITS-1:0] quo_q;
  logic               neg_q;
  logic [4:0]         cnt_q;
  logic signed [31:0] integ_acc;
  logic signed [16:0] prev_err;

  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_y;
  logic signed [16:0] err_next;
  logic signed [34:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic signed [17:0] diff;
  logic [17:0]        diff_mag;
  logic [16:0]        rem_shift;
  logic [17:0]        trial;
  logic [57:0]        prod_ext;
  logic [57:0]        prod_sh8;
  logic signed [47:0] drive_sat;
  logic [1:0]         band_next;

  assign stat.div_busy = (cnt_q != 5'd0);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.cw.mul_sel)
      MUL_ERR_PER: begin
        mul_a = {err_q[16], err_q};
        mul_b = {17'd0, cfg.period};
      end
      MUL_P: begin
        mul_a = {{2{cfg.gain_p[15]}}, cfg.gain_p};
        mul_b = {{16{err_q[16]}}, err_q};
      end
      MUL_I: begin
        mul_a = {{2{cfg.gain_i[15]}}, cfg.gain_i};
        mul_b = {integ_q[31], integ_q};
      end
      MUL_D: begin
        mul_a = {{2{cfg.gain_d[15]}}, cfg.gain_d};
        mul_b = {{7{deriv_q[25]}}, deriv_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_y = mul_a * mul_b;

  // Error and integral with 32-bit clamp
  assign err_next  = {cfg.target[15], cfg.target} - {meas_q[15], meas_q};
  assign integ_sum = {{3{integ_acc[31]}}, integ_acc} + {prod_q[33], prod_q[33:0]};
  always_comb begin
    if (integ_sum[34:31] == 4'b0000 || integ_sum[34:31] == 4'b1111) begin
      integ_sat = integ_sum[31:0];
    end else if (integ_sum[34]) begin
      integ_sat = {1'b1, 31'd0};
    end else begin
      integ_sat = {1'b0, {31{1'b1}}};
    end
  end

  // Divider: magnitude of (err - prev_err) * 256, one bit per step
  assign diff      = {err_q[16], err_q} - {prev_err[16], prev_err};
  assign diff_mag  = diff[17] ? (18'd0 - diff) : diff;
  assign rem_shift = {rem_q, quo_q[DIV_BITS-1]};
  assign trial     = {1'b0, rem_shift} - {2'd0, cfg.period};

  // Accumulator operand in Q8
  assign prod_ext = {{7{prod_q[50]}}, prod_q};
  assign prod_sh8 = {prod_ext[49:0], 8'd0};

  // Drive saturation to 48 bits
  always_comb begin
    if (acc_q[57:47] == '0 || acc_q[57:47] == '1) begin
      drive_sat = acc_q[47:0];
    end else if (acc_q[57]) begin
      drive_sat = {1'b1, 47'd0};
    end else begin
      drive_sat = {1'b0, {47{1'b1}}};
    end
  end

  // Band from the error sign and size
  always_comb begin
    if (err_q > 17'sd1) begin
      band_next = BAND_ABOVE;
    end else if (err_q < -17'sd1) begin
      band_next = BAND_BELOW;
    end else begin
      band_next = BAND_WITHIN;
    end
  end

  // Sample capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_q <= measured;
    end
  end

  // Multiplier output register and accumulator
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (cmd.cw.mul_sel != MUL_NONE) begin
        prod_q <= mul_y;
      end
      case (cmd.cw.acc_op)
        ACC_LOAD_SH8: acc_q <= prod_sh8;
        ACC_ADD_SH8:  acc_q <= acc_q + prod_sh8;
        ACC_ADD:      acc_q <= acc_q + prod_ext;
        default:      acc_q <= acc_q;
      endcase
    end
  end

  // Unit operations
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= 5'd0;
    end else if (cmd.step) begin
      case (cmd.cw.unit_op)
        UOP_ERR:   err_q   <= err_next;
        UOP_INTEG: integ_q <= integ_sat;
        UOP_DIV_INIT: begin
          neg_q <= diff[17];
          rem_q <= 16'd0;
          quo_q <= {diff_mag[16:0], 8'd0};
          cnt_q <= DIV_LAST;
        end
        UOP_DIV_STEP: begin
          if (!trial[17]) begin
            rem_q <= trial[15:0];
            quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
          end else begin
            rem_q <= rem_shift[15:0];
            quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
          end
          if (cnt_q != 5'd0) begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        UOP_DIV_FIN: begin
          // zero period gives a zero derivative
          if (cfg.period == 16'd0) begin
            deriv_q <= '0;
          end else if (neg_q) begin
            deriv_q <= 26'd0 - {1'b0, quo_q};
          end else begin
            deriv_q <= {1'b0, quo_q};
          end
        end
        default: ;
      endcase
    end
  end

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      prev_err  <= '0;
    end else if (cmd.step && cmd.cw.unit_op == UOP_DONE) begin
      integ_acc <= integ_q;
      prev_err  <= err_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.step && cmd.cw.unit_op == UOP_DONE) begin
      err_now   <= err_q;
      integ_now <= integ_q;
      deriv_now <= deriv_q;
      drive     <= drive_sat;
      band      <= band_next;
    end
  end

endmodule

// ===== rtl/core/pid_controller_with_band_indicator_top.sv =====
// ----------------------------------------------------------------------------
// pid_controller_with_band_indicator_top
// One sample is processed at a time; the next input is taken only after the
// last step of the item, and the 25-step restoring divider is its longest part.
// The next input is taken while a result waits; the last step holds until
// the output register is free. Synchronous reset restores register defaults
// and clears the integral and previous error.
// ----------------------------------------------------------------------------
module pid_controller_with_band_indicator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] measured,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] err_now,
  output logic signed [31:0] integ_now,
  output logic signed [25:0] deriv_now,
  output logic signed [47:0] drive,
  output logic [1:0]         band
);
  import pidb_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target <= TARGET_RST;
      cfg.period <= PERIOD_RST;
      cfg.gain_p <= GAIN_RST;
      cfg.gain_i <= GAIN_RST;
      cfg.gain_d <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: cfg.target <= cfg_data;
        REG_PERIOD: cfg.period <= cfg_data;
        REG_GAIN_P: cfg.gain_p <= cfg_data;
        REG_GAIN_I: cfg.gain_i <= cfg_data;
        REG_GAIN_D: cfg.gain_d <= cfg_data;
        default: ;
      endcase
    end
  end

  pidb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .measured  (measured),
    .err_now   (err_now),
    .integ_now (integ_now),
    .deriv_now (deriv_now),
    .drive     (drive),
    .band      (band)
  );

endmodule

// ===== test/pid_controller_with_band_indicator_top_tb.sv =====
// ----------------------------------------------------------------------------
// pid_controller_with_band_indicator_top_tb
// Self-checking bench for the PID controller with band indicator. Samples
// go in over a valid/ready channel with random gaps. Results come back
// through a stalling sink and are checked field by field against a PID
// model kept in the bench. Settings change between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module pid_controller_with_band_indicator_top_tb;
  import pidb_pkg::*;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;
  localparam longint DRIVE_MAX = 64'sd140737488355327;
  localparam longint DRIVE_MIN = -64'sd140737488355328;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 200;
  localparam int     SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [16:0] err;
    logic signed [31:0] integ;
    logic signed [25:0] deriv;
    logic signed [47:0] drv;
    logic [1:0]         band;
  } pid_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_TARGET;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] measured = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] err_now;
  logic signed [31:0] integ_now;
  logic signed [25:0] deriv_now;
  logic signed [47:0] drive;
  logic [1:0]         band;

  pid_controller_with_band_indicator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .err_now   (err_now),
    .integ_now (integ_now),
    .deriv_now (deriv_now),
    .drive     (drive),
    .band      (band)
  );

  // Controller model: settings plus the two state registers
  cfg_t        pid_cfg;
  longint      pid_integ;
  longint      pid_prev_err;

  logic [15:0] samples_pending[$];
  pid_result_t results_due[$];
  int          failures = 0;
  bit          no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // One control tick of the model: returns the result, advances the state
  function automatic pid_result_t pid_tick(input logic signed [15:0] meas);
    longint      tgt, per, gp, gi, gd, e, ig, dv, dr;
    pid_result_t r;
    tgt = $signed(pid_cfg.target);
    per = pid_cfg.period;
    gp  = $signed(pid_cfg.gain_p);
    gi  = $signed(pid_cfg.gain_i);
    gd  = $signed(pid_cfg.gain_d);
    e   = tgt - longint'(meas);
    ig  = pid_integ + e * per;
    if (ig > INTEG_MAX) ig = INTEG_MAX;
    if (ig < INTEG_MIN) ig = INTEG_MIN;
    // zero period: no derivative term at all
    dv = 0;
    if (per != 0) dv = ((e - pid_prev_err) * 256) / per;
    dr = gp * e * 256 + gi * ig * 256 + gd * dv;
    if (dr > DRIVE_MAX) dr = DRIVE_MAX;
    if (dr < DRIVE_MIN) dr = DRIVE_MIN;
    r.err   = e[16:0];
    r.integ = ig[31:0];
    r.deriv = dv[25:0];
    r.drv   = dr[47:0];
    if (e > 1) r.band = BAND_ABOVE;
    else if (e < -1) r.band = BAND_BELOW;
    else r.band = BAND_WITHIN;
    pid_integ    = ig;
    pid_prev_err = e;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Sample driver: predicts on each input transfer, then refills the slot
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) results_due.push_back(pid_tick(measured));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (samples_pending.size() != 0) begin
          in_valid <= 1'b1;
          measured <= samples_pending.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    pid_result_t due;
    if (rst) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          note_failure("result transfer with nothing outstanding");
        end else begin
          due = results_due.pop_front();
          if (err_now !== due.err)
            note_failure($sformatf("err_now exp %0d got %0d", due.err, err_now));
          if (integ_now !== due.integ)
            note_failure($sformatf("integ_now exp %0d got %0d", due.integ, integ_now));
          if (deriv_now !== due.deriv)
            note_failure($sformatf("deriv_now exp %0d got %0d", due.deriv, deriv_now));
          if (drive !== due.drv)
            note_failure($sformatf("drive exp %0d got %0d", due.drv, drive));
          if (band !== due.band)
            note_failure($sformatf("band exp %0d got %0d", due.band, band));
        end
      end
      if (sink_stall != 0) begin
        out_ready  <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) sink_stall <= pick_gap();
      end
    end
  end

  // Register write: the model copy follows at once, the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TARGET: pid_cfg.target = val;
      REG_PERIOD: pid_cfg.period = val;
      REG_GAIN_P: pid_cfg.gain_p = val;
      REG_GAIN_I: pid_cfg.gain_i = val;
      REG_GAIN_D: pid_cfg.gain_d = val;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every sample has gone in and every result come back;
  // a sample popped from the queue reaches in_valid through a register, so
  // a single quiet look at the channel is not enough
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk);
      if (samples_pending.size() != 0 || in_valid || results_due.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2:       return '0;
      default: return 16'($urandom_range(0, 128) - 64);
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2:       return '0;
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // Stimulus
  initial begin
    pid_cfg      = '{target: TARGET_RST, period: PERIOD_RST, gain_p: GAIN_RST,
                     gain_i: GAIN_RST, gain_d: GAIN_RST};
    pid_integ    = 0;
    pid_prev_err = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: error zero, band edges, full-scale samples
    samples_pending = '{16'd20, 16'd19, 16'd21, 16'd18, 16'd22, 16'd0,
                        16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
    drain();

    // Largest positive settings: integral and drive saturate high;
    // writes past the last register must be ignored
    write_reg(REG_TARGET, 16'h7fff);
    write_reg(REG_PERIOD, 16'hffff);
    write_reg(REG_GAIN_P, 16'h7fff);
    write_reg(REG_GAIN_I, 16'h7fff);
    write_reg(REG_GAIN_D, 16'h7fff);
    write_reg(3'd5, 16'h0000);
    write_reg(3'd6, 16'hffff);
    write_reg(3'd7, 16'h1234);
    close_writes();
    samples_pending = '{16'h8000, 16'h8000, 16'h7fff, 16'h5555};
    drain();

    // Most negative settings: integral swings to the low limit
    write_reg(REG_TARGET, 16'h8000);
    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h8000);
    write_reg(REG_GAIN_D, 16'h8000);
    close_writes();
    samples_pending = '{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff};
    drain();

    // Zero period: integral holds, derivative forced to zero
    write_reg(REG_PERIOD, 16'h0000);
    write_reg(REG_TARGET, 16'h0000);
    write_reg(REG_GAIN_P, 16'd3);
    write_reg(REG_GAIN_I, 16'hfffe);
    write_reg(REG_GAIN_D, 16'h7fff);
    close_writes();
    samples_pending = '{16'd0, 16'd1, 16'hffff, 16'd2, 16'hfffe, 16'haaaa};
    drain();

    // Unit period
    write_reg(REG_PERIOD, 16'd1);
    write_reg(REG_GAIN_P, 16'd1);
    write_reg(REG_GAIN_I, 16'd1);
    write_reg(REG_GAIN_D, 16'd1);
    write_reg(REG_TARGET, 16'h1234);
    close_writes();
    samples_pending = '{16'h1234, 16'h0000};
    drain();

    // Random phases: fresh settings each, samples mostly near the setpoint
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph == 2);
      write_reg(REG_TARGET, pick_target());
      write_reg(REG_PERIOD, pick_period());
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      close_writes();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 3))
          0, 1: samples_pending.push_back(pid_cfg.target + 16'($urandom_range(0, 8) - 4));
          2:    samples_pending.push_back(pid_cfg.target + 16'($urandom_range(0, 2000) - 1000));
          default: samples_pending.push_back(16'($urandom));
        endcase
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pidb_pkg.sv
rtl/core/pidb_seq.sv
rtl/core/pidb_dp.sv
rtl/core/pid_controller_with_band_indicator_top.sv
test/pid_controller_with_band_indicator_top_tb.sv
